// ===== design/rau_pkg.sv =====
// Shared types, widths and codes for the rational arithmetic unit.
package rau_pkg;

  // Operand width in bits. Legal values run from 8 to 32.
  localparam int OPERAND_WIDTH = 32;
  // Cross products and sums are held at double width.
  localparam int PW = 2 * OPERAND_WIDTH;
  // Binary GCD takes at most one step per bit of both values.
  localparam int GCD_STEPS = 2 * PW;
  // Width of the count of common factors of two.
  localparam int KW = $clog2(PW);

  typedef logic [OPERAND_WIDTH-1:0] opmag_t;
  typedef logic [PW-1:0] mag_t;
  typedef logic [KW-1:0] shift_t;

  // Operation codes on the action field.
  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ZERO_DEN = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // Control that travels with each item down the pipeline.
  typedef struct packed {
    logic valid;
    logic err;
    logic zero;
    logic neg;
  } side_t;

endpackage

// ===== design/rau_if.sv =====
// Request and response channel interfaces of the rational arithmetic unit.
interface rau_req_if;
  logic valid;
  logic ready;
  logic [1:0] action;
  logic signed [31:0] a_num;
  logic signed [31:0] a_den;
  logic signed [31:0] b_num;
  logic signed [31:0] b_den;

  modport source (output valid, action, a_num, a_den, b_num, b_den, input ready);
  modport sink (input valid, action, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if;
  logic valid;
  logic ready;
  logic signed [31:0] result_num;
  logic [30:0] result_den;
  logic [1:0] status;

  modport source (output valid, result_num, result_den, status, input ready);
  modport sink (input valid, result_num, result_den, status, output ready);
endinterface

// ===== design/rau_gcd.sv =====
// Binary GCD pipeline: one Stein step per register stage.
module rau_gcd
  import rau_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   en,
  input  side_t  side_in,
  input  mag_t   n_in,
  input  mag_t   d_in,
  output side_t  side_out,
  output mag_t   n_out,
  output mag_t   d_out,
  output mag_t   odd_out,
  output shift_t k_out
);

  typedef struct packed {
    mag_t   u;
    mag_t   v;
    shift_t k;
  } gst_t;

  side_t sd [GCD_STEPS];
  mag_t  nn [GCD_STEPS];
  mag_t  dd [GCD_STEPS];
  gst_t  st [GCD_STEPS];
  gst_t  st_next [GCD_STEPS];

  // One step: strip common twos, strip a lone two, or halve the difference.
  function automatic gst_t gcd_step(gst_t s);
    gst_t r;
    r = s;
    if (s.u == '0 || s.v == '0) begin
      r = s;
    end else if (!s.u[0] && !s.v[0]) begin
      r.u = s.u >> 1;
      r.v = s.v >> 1;
      r.k = s.k + 1'b1;
    end else if (!s.u[0]) begin
      r.u = s.u >> 1;
    end else if (!s.v[0]) begin
      r.v = s.v >> 1;
    end else if (s.u >= s.v) begin
      r.u = (s.u - s.v) >> 1;
    end else begin
      r.v = (s.v - s.u) >> 1;
    end
    return r;
  endfunction

  // Each stage steps on the previous stage's state.
  always_comb begin
    for (int i = 0; i < GCD_STEPS; i++) begin
      if (i == 0) begin
        st_next[i] = gcd_step('{u: n_in, v: d_in, k: '0});
      end else begin
        st_next[i] = gcd_step(st[i-1]);
      end
    end
  end

  // Stage registers; the whole chain moves only when enabled.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < GCD_STEPS; i++) begin
        sd[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < GCD_STEPS; i++) begin
        if (i == 0) begin
          sd[i] <= side_in;
          nn[i] <= n_in;
          dd[i] <= d_in;
        end else begin
          sd[i] <= sd[i-1];
          nn[i] <= nn[i-1];
          dd[i] <= dd[i-1];
        end
        st[i] <= st_next[i];
      end
    end
  end

  assign side_out = sd[GCD_STEPS-1];
  assign n_out    = nn[GCD_STEPS-1];
  assign d_out    = dd[GCD_STEPS-1];
  assign odd_out  = st[GCD_STEPS-1].u | st[GCD_STEPS-1].v;
  assign k_out    = st[GCD_STEPS-1].k;

endmodule

// ===== design/rau_div.sv =====
// Restoring divider pipeline: numerator and denominator share one divisor.
module rau_div
  import rau_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  side_t side_in,
  input  mag_t  n_in,
  input  mag_t  d_in,
  input  mag_t  divisor,
  output side_t side_out,
  output mag_t  nq_out,
  output mag_t  dq_out
);

  typedef struct packed {
    mag_t rem;
    mag_t q;
  } dst_t;

  side_t sd [PW];
  mag_t  dv [PW];
  dst_t  sn [PW];
  dst_t  sdn [PW];
  dst_t  sn_next [PW];
  dst_t  sdn_next [PW];

  // Bring down one dividend bit and subtract if the divisor fits.
  function automatic dst_t div_step(dst_t s, mag_t dvs);
    logic [PW:0] r2;
    dst_t r;
    r2 = {s.rem, s.q[PW-1]};
    r.q = {s.q[PW-2:0], 1'b0};
    if (r2 >= {1'b0, dvs}) begin
      r2 = r2 - {1'b0, dvs};
      r.q[0] = 1'b1;
    end
    r.rem = r2[PW-1:0];
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < PW; i++) begin
      if (i == 0) begin
        sn_next[i]  = div_step('{rem: '0, q: n_in}, divisor);
        sdn_next[i] = div_step('{rem: '0, q: d_in}, divisor);
      end else begin
        sn_next[i]  = div_step(sn[i-1], dv[i-1]);
        sdn_next[i] = div_step(sdn[i-1], dv[i-1]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PW; i++) begin
        sd[i].valid <= 1'b0;
      end
    end else if (en) begin
      for (int i = 0; i < PW; i++) begin
        if (i == 0) begin
          sd[i] <= side_in;
          dv[i] <= divisor;
        end else begin
          sd[i] <= sd[i-1];
          dv[i] <= dv[i-1];
        end
        sn[i]  <= sn_next[i];
        sdn[i] <= sdn_next[i];
      end
    end
  end

  assign side_out = sd[PW-1];
  assign nq_out   = sn[PW-1].q;
  assign dq_out   = sdn[PW-1].q;

endmodule

// ===== design/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit.
//
// The req channel carries one operation (add, subtract, multiply, divide)
// on two signed fractions; the rsp channel returns one reduced fraction and
// a status for each transaction, in order. Both use valid/ready handshakes.
// The block is a single pipeline: decode, cross products, signed sum,
// 128 binary GCD steps, a shift, 64 restoring division steps and the output
// register. One request can be accepted in every cycle that the pipeline is
// not frozen, so throughput is one transaction per cycle while the receiver
// keeps rsp ready high; the GCD step chain is the longest part of the pipeline.
// When the receiver holds rsp ready low while a result waits, the whole
// pipeline freezes and req ready drops, so nothing is lost or repeated.
// Synchronous reset clears every stage's valid bit; payload registers are
// not reset. Zero denominators report status 1 with a 0/0 result, results
// that do not fit report status 2 with a 0/0 result.
module rational_arithmetic_unit
  import rau_pkg::*;
(
  input logic     clk,
  input logic     rst,
  rau_req_if.sink req,
  rau_rsp_if.source rsp
);

  localparam mag_t LIM = mag_t'(1) << (OPERAND_WIDTH - 1);

  logic en;

  // Stage 1: sign and magnitude of each operand.
  side_t      s1_side;
  logic [1:0] s1_act;
  opmag_t     s1_an, s1_ad, s1_bn, s1_bd;
  logic       s1_ann, s1_adn, s1_bnn, s1_bdn;

  // Stage 2: cross products.
  side_t s2_side;
  mag_t  s2_p1, s2_p2, s2_p3;
  logic  s2_n1, s2_n2, s2_dn;

  // Stage 3: signed numerator sum.
  side_t s3_side;
  mag_t  s3_n, s3_d;

  // GCD outputs.
  side_t  g_side;
  mag_t   g_n, g_d, g_odd;
  shift_t g_k;

  // Shift stage feeding the divider.
  side_t sh_side;
  mag_t  sh_n, sh_d, sh_odd;

  // Divider outputs.
  side_t q_side;
  mag_t  q_n, q_d;

  // Output register.
  logic              out_valid;
  logic signed [31:0] out_num;
  logic [30:0]       out_den;
  status_t           out_status;

  // The pipeline advances whenever the output register is free or taken.
  assign en        = !out_valid || rsp.ready;
  assign req.ready = en;

  // Operand decode helpers.
  function automatic logic op_neg(logic [31:0] raw);
    return raw[OPERAND_WIDTH-1];
  endfunction

  function automatic opmag_t op_mag(logic [31:0] raw);
    opmag_t v;
    v = raw[OPERAND_WIDTH-1:0];
    return v[OPERAND_WIDTH-1] ? opmag_t'(-v) : v;
  endfunction

  // Stage 1 register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_side.valid <= 1'b0;
    end else if (en) begin
      s1_side.valid <= req.valid;
      s1_side.err   <= (op_mag(req.a_den) == '0) || (op_mag(req.b_den) == '0) ||
                       (req.action == ACT_DIV && op_mag(req.b_num) == '0);
      s1_side.zero  <= 1'b0;
      s1_side.neg   <= 1'b0;
      s1_act <= req.action;
      s1_an  <= op_mag(req.a_num);
      s1_ad  <= op_mag(req.a_den);
      s1_bn  <= op_mag(req.b_num);
      s1_bd  <= op_mag(req.b_den);
      s1_ann <= op_neg(req.a_num);
      s1_adn <= op_neg(req.a_den);
      s1_bnn <= op_neg(req.b_num);
      s1_bdn <= op_neg(req.b_den);
    end
  end

  // Stage 2: choose the factors for the operation and multiply.
  opmag_t y1, y3;
  logic   y1n, y3n, use_p2;

  always_comb begin
    y1     = (s1_act == ACT_MUL) ? s1_bn : s1_bd;
    y1n    = (s1_act == ACT_MUL) ? s1_bnn : s1_bdn;
    y3     = (s1_act == ACT_DIV) ? s1_bn : s1_bd;
    y3n    = (s1_act == ACT_DIV) ? s1_bnn : s1_bdn;
    use_p2 = (s1_act == ACT_ADD) || (s1_act == ACT_SUB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_side.valid <= 1'b0;
    end else if (en) begin
      s2_side <= s1_side;
      s2_p1   <= mag_t'(s1_an) * mag_t'(y1);
      s2_p2   <= use_p2 ? mag_t'(s1_bn) * mag_t'(s1_ad) : '0;
      s2_p3   <= mag_t'(s1_ad) * mag_t'(y3);
      s2_n1   <= s1_ann ^ y1n;
      s2_n2   <= s1_bnn ^ s1_adn ^ (s1_act == ACT_SUB);
      s2_dn   <= s1_adn ^ y3n;
    end
  end

  // Stage 3: sign-magnitude add of the two numerator terms.
  mag_t s3_n_next;
  logic s3_nn_next;

  always_comb begin
    if (s2_n1 == s2_n2) begin
      s3_n_next  = s2_p1 + s2_p2;
      s3_nn_next = s2_n1;
    end else if (s2_p1 >= s2_p2) begin
      s3_n_next  = s2_p1 - s2_p2;
      s3_nn_next = s2_n1;
    end else begin
      s3_n_next  = s2_p2 - s2_p1;
      s3_nn_next = s2_n2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_side.valid <= 1'b0;
    end else if (en) begin
      s3_side.valid <= s2_side.valid;
      s3_side.err   <= s2_side.err;
      s3_side.zero  <= (s3_n_next == '0);
      s3_side.neg   <= s3_nn_next ^ s2_dn;
      s3_n          <= s3_n_next;
      s3_d          <= s2_p3;
    end
  end

  rau_gcd u_gcd (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (s3_side),
    .n_in     (s3_n),
    .d_in     (s3_d),
    .side_out (g_side),
    .n_out    (g_n),
    .d_out    (g_d),
    .odd_out  (g_odd),
    .k_out    (g_k)
  );

  // Remove the common power of two before the odd-divisor division.
  always_ff @(posedge clk) begin
    if (rst) begin
      sh_side.valid <= 1'b0;
    end else if (en) begin
      sh_side <= g_side;
      sh_n    <= g_n >> g_k;
      sh_d    <= g_d >> g_k;
      sh_odd  <= g_odd;
    end
  end

  rau_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .side_in  (sh_side),
    .n_in     (sh_n),
    .d_in     (sh_d),
    .divisor  (sh_odd),
    .side_out (q_side),
    .nq_out   (q_n),
    .dq_out   (q_d)
  );

  // Range check and final formatting.
  logic   ovf;
  opmag_t num_w;

  always_comb begin
    ovf   = (q_d > LIM - 1'b1) || (q_n > (q_side.neg ? LIM : LIM - 1'b1));
    num_w = q_side.neg ? opmag_t'(-q_n[OPERAND_WIDTH-1:0]) : q_n[OPERAND_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= q_side.valid;
      if (q_side.err) begin
        out_num    <= '0;
        out_den    <= '0;
        out_status <= ST_ZERO_DEN;
      end else if (q_side.zero) begin
        out_num    <= '0;
        out_den    <= 31'd1;
        out_status <= ST_OK;
      end else if (ovf) begin
        out_num    <= '0;
        out_den    <= '0;
        out_status <= ST_OVERFLOW;
      end else begin
        out_num    <= 32'(signed'(num_w));
        out_den    <= 31'(q_d);
        out_status <= ST_OK;
      end
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.result_num = out_num;
  assign rsp.result_den = out_den;
  assign rsp.status     = out_status;

endmodule

// ===== design/rau_check.sv =====
// Port-level assertions for the rational arithmetic unit, bound to the top level.
module rau_check
  import rau_pkg::*;
(
  input logic       clk,
  input logic       rst,
  rau_req_if.sink   req,
  rau_rsp_if.source rsp
);

  // An offered ok result always has a positive denominator.
  a_ok_den: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status == ST_OK |-> rsp.result_den != '0)
    else $error("ok result with zero denominator");

  // Error results carry a zero fraction.
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.status != ST_OK |-> rsp.result_num == '0 && rsp.result_den == '0)
    else $error("error result with nonzero fraction");

  // Nothing is offered right after reset.
  a_reset: assert property (@(posedge clk) rst |=> !rsp.valid)
    else $error("response valid after reset");

  // With no response waiting, the block takes requests.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !rsp.valid |-> req.ready)
    else $error("request stalled with empty output");

  // A stalled response holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.result_num) &&
    $stable(rsp.result_den) && $stable(rsp.status))
    else $error("stalled response changed");

endmodule

bind rational_arithmetic_unit rau_check u_rau_check (
  .clk (clk),
  .rst (rst),
  .req (req),
  .rsp (rsp)
);
